[src/trail_catmull_rom_tessellator_macros.svh]
// Assertion helpers for the tessellator RTL.
`ifndef TRAIL_CATMULL_ROM_TESSELLATOR_MACROS_SVH
`define TRAIL_CATMULL_ROM_TESSELLATOR_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define TRC_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define TRC_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[src/trc_pkg.sv]
`default_nettype none

package trc_pkg;

    localparam int NUM_RAILS    = 2;
    localparam int NUM_POINTS   = 5;
    localparam int NUM_COORDS   = 4;
    localparam int NUM_TAPS     = 4;
    localparam int WIN_DEPTH    = 7;
    localparam int NUM_SEGS     = 4;
    localparam int SEG_STEPS    = 10;

    localparam int COORD_W      = 32;
    localparam int WEIGHT_W     = 12;
    localparam int PROD_W       = 44;
    localparam int SUM_W        = 46;
    localparam int WEIGHT_SHIFT = 10;
    localparam int QUOT_W       = 36;
    localparam int TIME_W       = 24;
    localparam int ACC_W        = 32;
    localparam int IDX_W        = 6;
    localparam int WSEL_W       = 4;

    localparam logic [TIME_W-1:0] MODE1_INTERVAL = 24'd3277;
    localparam logic [IDX_W-1:0]  LAST_INDEX     = 6'd39;

    // trail_mode codes
    localparam logic MODE_DIRECT = 1'b0;
    localparam logic MODE_LAG    = 1'b1;

    // configuration register indexes
    localparam logic CFG_TRAIL_MODE  = 1'b0;
    localparam logic CFG_FOLLOW_TIME = 1'b1;

    // weight select code that passes window tap 2 through unchanged
    localparam logic [WSEL_W-1:0] WSEL_PASS = 4'd9;

    typedef logic [NUM_COORDS-1:0][COORD_W-1:0] point_t;   // [0]=x .. [3]=w
    typedef logic signed [WEIGHT_W-1:0] weight_t;
    typedef weight_t weight_set_t [NUM_TAPS];

    typedef enum logic {
        SEQ_IDLE,
        SEQ_RUN
    } seq_state_t;

    typedef struct packed {
        logic [WSEL_W-1:0] wsel;
        logic              shift_win;
        logic              last;
    } ucode_t;

    typedef struct packed {
        logic              issue;
        logic [WSEL_W-1:0] wsel;
        logic              shift_win;
        logic              last;
        logic [IDX_W-1:0]  index;
    } ctrl_t;

    // Catmull-Rom weights at t = j/8, scaled by 1024.
    function automatic weight_set_t weight_rom(logic [WSEL_W-1:0] sel);
        weight_set_t w;
        case (sel)
            4'd0:    w = '{12'sd0,    12'sd1024, 12'sd0,    12'sd0};
            4'd1:    w = '{-12'sd49,  12'sd987,  12'sd93,   -12'sd7};
            4'd2:    w = '{-12'sd72,  12'sd888,  12'sd232,  -12'sd24};
            4'd3:    w = '{-12'sd75,  12'sd745,  12'sd399,  -12'sd45};
            4'd4:    w = '{-12'sd64,  12'sd576,  12'sd576,  -12'sd64};
            4'd5:    w = '{-12'sd45,  12'sd399,  12'sd745,  -12'sd75};
            4'd6:    w = '{-12'sd24,  12'sd232,  12'sd888,  -12'sd72};
            4'd7:    w = '{-12'sd7,   12'sd93,   12'sd987,  -12'sd49};
            4'd8:    w = '{12'sd0,    12'sd0,    12'sd1024, 12'sd0};
            default: w = '{12'sd0,    12'sd0,    12'sd1024, 12'sd0};
        endcase
        return w;
    endfunction

    // Emission program: one word per slot, step 9 of each segment slides
    // the window, the final word jumps back to idle.
    function automatic ucode_t ucode_rom(logic [IDX_W-1:0] addr);
        ucode_t word;
        word.wsel      = WSEL_PASS;
        word.shift_win = 1'b0;
        word.last      = 1'b1;
        for (int s = 0; s < NUM_SEGS; s++) begin
            for (int j = 0; j < SEG_STEPS; j++) begin
                if (addr == IDX_W'(s * SEG_STEPS + j)) begin
                    word.wsel      = WSEL_W'(j);
                    word.shift_win = (j == SEG_STEPS - 1);
                    word.last      = (s == NUM_SEGS - 1) && (j == SEG_STEPS - 1);
                end
            end
        end
        return word;
    endfunction

endpackage

`default_nettype wire

[src/trc_sequencer.sv]
`default_nettype none

module trc_sequencer (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          start,
    input  wire logic          advance,
    output trc_pkg::ctrl_t     ctrl,
    output logic               busy
);

    trc_pkg::seq_state_t           state_reg, state_next;
    logic [trc_pkg::IDX_W-1:0]     pc_reg, pc_next;
    trc_pkg::ucode_t               word;

    always_comb word = trc_pkg::ucode_rom(pc_reg);

    always_comb
    begin
        state_next = state_reg;
        pc_next    = pc_reg;
        unique case (state_reg)
            trc_pkg::SEQ_IDLE:
            begin
                if (start)
                begin
                    state_next = trc_pkg::SEQ_RUN;
                    pc_next    = '0;
                end
            end
            trc_pkg::SEQ_RUN:
            begin
                if (advance)
                begin
                    if (word.last)
                    begin
                        state_next = trc_pkg::SEQ_IDLE;
                        pc_next    = '0;
                    end
                    else
                    begin
                        pc_next = pc_reg + trc_pkg::IDX_W'(1);
                    end
                end
            end
            default:
            begin
                state_next = trc_pkg::SEQ_IDLE;
                pc_next    = '0;
            end
        endcase
    end

    always_comb
    begin
        ctrl.issue     = (state_reg == trc_pkg::SEQ_RUN);
        ctrl.wsel      = word.wsel;
        ctrl.shift_win = word.shift_win;
        ctrl.last      = word.last;
        ctrl.index     = pc_reg;
        busy           = (state_reg == trc_pkg::SEQ_RUN);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= trc_pkg::SEQ_IDLE;
            pc_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            pc_reg    <= pc_next;
        end
    end

endmodule

`default_nettype wire

[src/trail_catmull_rom_tessellator.sv]
// Flow: an accepted item starts the sequencer; each vertex pair then passes
// the product, sum and output registers, one pair per cycle while out_ready
// holds, 40 in all. A new item is taken only once the 40-word emission program
// and the 3-stage multiply/add/saturate path drain. Downstream stalls freeze all.
// Reset: control points, time accumulator, trail_mode and follow_time clear
// to zero at once; no clearing pass.
`default_nettype none

`include "trail_catmull_rom_tessellator_macros.svh"

module trail_catmull_rom_tessellator (
    input  wire logic        clk,
    input  wire logic        rst_n,

    input  wire logic        cfg_write_en,
    input  wire logic        cfg_index,
    input  wire logic [23:0] cfg_data,

    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [23:0] elapsed_time,
    input  wire logic signed [31:0] head_a_x,
    input  wire logic signed [31:0] head_a_y,
    input  wire logic signed [31:0] head_a_z,
    input  wire logic signed [31:0] head_a_w,
    input  wire logic signed [31:0] head_b_x,
    input  wire logic signed [31:0] head_b_y,
    input  wire logic signed [31:0] head_b_z,
    input  wire logic signed [31:0] head_b_w,

    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [5:0]       vertex_index,
    output logic signed [31:0] vert_a_x,
    output logic signed [31:0] vert_a_y,
    output logic signed [31:0] vert_a_z,
    output logic signed [31:0] vert_a_w,
    output logic signed [31:0] vert_b_x,
    output logic signed [31:0] vert_b_y,
    output logic signed [31:0] vert_b_z,
    output logic signed [31:0] vert_b_w,
    output logic             last_vertex
);

    localparam int NR = trc_pkg::NUM_RAILS;
    localparam int NP = trc_pkg::NUM_POINTS;
    localparam int NC = trc_pkg::NUM_COORDS;
    localparam int NT = trc_pkg::NUM_TAPS;
    localparam int WD = trc_pkg::WIN_DEPTH;

    localparam logic signed [trc_pkg::QUOT_W-1:0] SAT_MAX = 36'sd2147483647;
    localparam logic signed [trc_pkg::QUOT_W-1:0] SAT_MIN = -36'sd2147483648;

    // configuration
    logic                          trail_mode_reg;
    logic [trc_pkg::TIME_W-1:0]    follow_time_reg;

    // trail state
    trc_pkg::point_t               cp_reg   [NR][NP];
    trc_pkg::point_t               cp_next  [NR][NP];
    logic [trc_pkg::ACC_W-1:0]     acc_reg, acc_next;
    trc_pkg::point_t               head_pt  [NR];
    logic [trc_pkg::ACC_W:0]       acc_sum;
    logic [trc_pkg::ACC_W-1:0]     acc_sat;
    logic [trc_pkg::TIME_W-1:0]    limit;
    logic                          do_shift;

    // sliding window over P0,P0,P1,P2,P3,P4,P4
    trc_pkg::point_t               win_reg  [NR][WD];

    // sequencer
    trc_pkg::ctrl_t                ctrl;
    logic                          seq_busy;
    logic                          accept;
    logic                          advance;
    trc_pkg::weight_set_t          wset;

    // pipeline
    logic                          s1_valid_reg;
    logic                          s1_last_reg;
    logic [trc_pkg::IDX_W-1:0]     s1_index_reg;
    logic signed [trc_pkg::PROD_W-1:0] prod_reg [NR][NC][NT];
    logic                          s2_valid_reg;
    logic                          s2_last_reg;
    logic [trc_pkg::IDX_W-1:0]     s2_index_reg;
    logic signed [trc_pkg::SUM_W-1:0]  sum_reg [NR][NC];
    logic                          out_valid_reg;
    logic                          out_last_reg;
    logic [trc_pkg::IDX_W-1:0]     out_index_reg;
    logic [trc_pkg::COORD_W-1:0]   vert_reg [NR][NC];

    trc_sequencer u_seq (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (accept),
        .advance (advance),
        .ctrl    (ctrl),
        .busy    (seq_busy)
    );

    assign in_ready = !seq_busy && !s1_valid_reg && !s2_valid_reg && !out_valid_reg;
    assign accept   = in_valid && in_ready;
    assign advance  = !out_valid_reg || out_ready;

    always_comb wset = trc_pkg::weight_rom(ctrl.wsel);

    // ---- tick update ----
    always_comb
    begin
        head_pt[0] = {head_a_w, head_a_z, head_a_y, head_a_x};
        head_pt[1] = {head_b_w, head_b_z, head_b_y, head_b_x};

        acc_sum  = {1'b0, acc_reg} + (trc_pkg::ACC_W + 1)'(elapsed_time);
        acc_sat  = acc_sum[trc_pkg::ACC_W] ? '1 : acc_sum[trc_pkg::ACC_W-1:0];
        limit    = (trail_mode_reg == trc_pkg::MODE_DIRECT) ? follow_time_reg
                                                           : trc_pkg::MODE1_INTERVAL;
        do_shift = acc_sat > trc_pkg::ACC_W'(limit);
        acc_next = do_shift ? '0 : acc_sat;

        for (int r = 0; r < NR; r++)
        begin
            for (int p = 0; p < NP; p++)
                cp_next[r][p] = cp_reg[r][p];
            cp_next[r][0] = head_pt[r];
            cp_next[r][1] = (trail_mode_reg == trc_pkg::MODE_LAG) ? cp_reg[r][0]
                                                                  : head_pt[r];
            if (do_shift)
            begin
                cp_next[r][4] = cp_reg[r][3];
                cp_next[r][3] = cp_reg[r][2];
                cp_next[r][2] = cp_next[r][1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            trail_mode_reg  <= trc_pkg::MODE_DIRECT;
            follow_time_reg <= '0;
        end
        else if (cfg_write_en)
        begin
            unique case (cfg_index)
                trc_pkg::CFG_TRAIL_MODE:  trail_mode_reg  <= cfg_data[0];
                trc_pkg::CFG_FOLLOW_TIME: follow_time_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg <= '0;
            for (int r = 0; r < NR; r++)
                for (int p = 0; p < NP; p++)
                    cp_reg[r][p] <= '0;
        end
        else if (accept)
        begin
            acc_reg <= acc_next;
            for (int r = 0; r < NR; r++)
                for (int p = 0; p < NP; p++)
                    cp_reg[r][p] <= cp_next[r][p];
        end
    end

    // window loads on a tick and slides one point per segment
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            for (int r = 0; r < NR; r++)
            begin
                win_reg[r][0] <= cp_next[r][0];
                win_reg[r][1] <= cp_next[r][0];
                win_reg[r][2] <= cp_next[r][1];
                win_reg[r][3] <= cp_next[r][2];
                win_reg[r][4] <= cp_next[r][3];
                win_reg[r][5] <= cp_next[r][4];
                win_reg[r][6] <= cp_next[r][4];
            end
        end
        else if (advance && ctrl.issue && ctrl.shift_win)
        begin
            for (int r = 0; r < NR; r++)
                for (int i = 0; i < WD - 1; i++)
                    win_reg[r][i] <= win_reg[r][i+1];
        end
    end

    // ---- pipeline control ----
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s1_valid_reg  <= ctrl.issue;
            s2_valid_reg  <= s1_valid_reg;
            out_valid_reg <= s2_valid_reg;
        end
    end

    // arithmetic shift is the floor division by 1024
    function automatic logic [trc_pkg::COORD_W-1:0] sat_coord(
        logic signed [trc_pkg::SUM_W-1:0] s);
        logic signed [trc_pkg::QUOT_W-1:0] q;
        logic [trc_pkg::COORD_W-1:0]       v;
        q = trc_pkg::QUOT_W'(s >>> trc_pkg::WEIGHT_SHIFT);
        if (q > SAT_MAX)
            v = SAT_MAX[trc_pkg::COORD_W-1:0];
        else if (q < SAT_MIN)
            v = SAT_MIN[trc_pkg::COORD_W-1:0];
        else
            v = q[trc_pkg::COORD_W-1:0];
        return v;
    endfunction

    // ---- pipeline datapath: multiply, add, floor and saturate ----
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s1_last_reg   <= ctrl.last;
            s1_index_reg  <= ctrl.index;
            s2_last_reg   <= s1_last_reg;
            s2_index_reg  <= s1_index_reg;
            out_last_reg  <= s2_last_reg;
            out_index_reg <= s2_index_reg;
            for (int r = 0; r < NR; r++)
            begin
                for (int c = 0; c < NC; c++)
                begin
                    for (int t = 0; t < NT; t++)
                        prod_reg[r][c][t] <= trc_pkg::PROD_W'($signed(win_reg[r][t][c]))
                                           * trc_pkg::PROD_W'(wset[t]);
                    sum_reg[r][c] <= trc_pkg::SUM_W'(prod_reg[r][c][0])
                                   + trc_pkg::SUM_W'(prod_reg[r][c][1])
                                   + trc_pkg::SUM_W'(prod_reg[r][c][2])
                                   + trc_pkg::SUM_W'(prod_reg[r][c][3]);
                    vert_reg[r][c] <= sat_coord(sum_reg[r][c]);
                end
            end
        end
    end

    assign out_valid    = out_valid_reg;
    assign vertex_index = out_index_reg;
    assign last_vertex  = out_last_reg;
    assign vert_a_x     = vert_reg[0][0];
    assign vert_a_y     = vert_reg[0][1];
    assign vert_a_z     = vert_reg[0][2];
    assign vert_a_w     = vert_reg[0][3];
    assign vert_b_x     = vert_reg[1][0];
    assign vert_b_y     = vert_reg[1][1];
    assign vert_b_z     = vert_reg[1][2];
    assign vert_b_w     = vert_reg[1][3];

    `TRC_ASSERT_IMP(a_ready_only_when_drained, in_ready, !out_valid && !s1_valid_reg, "in_ready while results pending")
    `TRC_ASSERT_IMP(a_last_on_final_slot, out_valid && last_vertex, vertex_index == trc_pkg::LAST_INDEX, "last_vertex on wrong slot")
    `TRC_ASSERT_NXT(a_drained_after_last, out_valid && out_ready && last_vertex, in_ready, "not ready after final slot")

endmodule

`default_nettype wire
